// ----- rtl/lpmf_pkg.sv -----
// Shared types and constants for the length-prefixed message FIFO.
// Used by the controller, the datapath and the top level; depends on nothing.
package lpmf_pkg;

   localparam int FUNC_W      = 2;
   localparam int LEN_W       = 6;
   localparam int BYTE_W      = 8;
   localparam int STATUS_W    = 3;
   localparam int CSR_W       = 9;
   localparam int MSG_CNT_W   = 8;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_TUSER_W = 4;

   localparam logic [CSR_W-1:0] CSR_SIZE_RESET = 9'd256;
   localparam logic [CSR_W-1:0] CSR_SIZE_MIN   = 9'd2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_BEGIN     = 2'd0,
      FUNC_DATA      = 2'd1,
      FUNC_READ_MSG  = 2'd2,
      FUNC_READ_BYTE = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_EMPTY    = 3'd1,
      STAT_TOO_LONG = 3'd2,
      STAT_DROPPED  = 3'd3,
      STAT_IGNORED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE     = 2'd0,
      S_POP_WAIT = 2'd1,
      S_LEN_WAIT = 2'd2,
      S_DATA     = 2'd3
   } state_type;

   typedef enum logic [1:0] {
      OSEL_STATUS = 2'd0,
      OSEL_BYTE   = 2'd1,
      OSEL_MSG    = 2'd2
   } out_sel_type;

   typedef struct packed {
      logic        push_len;
      logic        push_data;
      logic        pop;
      logic        msg_dec;
      logic        msg_clr;
      logic        load_cnt;
      logic        out_load;
      out_sel_type out_sel;
      status_type  out_status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic msg_open;
      logic len_too_long;
      logic no_space;
      logic fill_zero;
      logic msg_zero;
      logic cnt_zero;
      logic last_beat;
   } dp_status_type;

endpackage

// ----- rtl/lpmf_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module lpmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lpmf_datapath.sv -----
// Datapath of the message FIFO: byte store, pointers, counters, size register
// and the result register. Depends on lpmf_pkg and lpmf_ram.
module lpmf_datapath #(
   parameter int STORE_DEPTH = 256,
   parameter int MAX_MSG_LEN = 63
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [lpmf_pkg::CSR_W-1:0]          csr_wr_data,
   input  logic [lpmf_pkg::LEN_W-1:0]          req_len,
   input  logic [lpmf_pkg::BYTE_W-1:0]         req_byte,
   input  lpmf_pkg::ctrl_cmd_type              cmd,
   output lpmf_pkg::dp_status_type             status,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lpmf_pkg::STATUS_W-1:0]       rsp_status,
   output logic [lpmf_pkg::BYTE_W-1:0]         rsp_byte,
   output logic [lpmf_pkg::LEN_W-1:0]          rsp_len,
   output logic                                rsp_byte_valid,
   output logic                                rsp_last
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int SW = $clog2(STORE_DEPTH + 1);
   localparam int CW = (SW > lpmf_pkg::BYTE_W) ? SW : lpmf_pkg::BYTE_W;
   localparam int BW = lpmf_pkg::BYTE_W;
   localparam int LW = lpmf_pkg::LEN_W;
   localparam int MW = lpmf_pkg::MSG_CNT_W;

   logic [lpmf_pkg::CSR_W-1:0] size_ff, size_in;
   logic [AW-1:0]              rd_ff, rd_in;
   logic [AW-1:0]              wr_ff, wr_in;
   logic [SW-1:0]              fill_ff, fill_in;
   logic [MW-1:0]              msg_cnt_ff, msg_cnt_in;
   logic [LW-1:0]              expect_ff, expect_in;
   logic [LW-1:0]              remain_ff, remain_in;
   logic [LW-1:0]              cnt_len_ff, cnt_len_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lpmf_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [BW-1:0]              rsp_byte_ff, rsp_byte_in;
   logic [LW-1:0]              rsp_len_ff, rsp_len_in;
   logic                       rsp_bval_ff, rsp_bval_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [SW-1:0] eff_size;
   logic [AW-1:0] rd_eff, wr_eff, rd_next, wr_next;
   logic [SW-1:0] free_space;
   logic [BW-1:0] rd_data;
   logic [BW-1:0] len_clamped;
   logic [CW-1:0] cnt_wide;
   logic [LW-1:0] cnt;
   logic          push;
   logic          out_free;

   assign push = cmd.push_len | cmd.push_data;

   always_comb begin
      if (size_ff < lpmf_pkg::CSR_SIZE_MIN) begin
         eff_size = SW'(lpmf_pkg::CSR_SIZE_MIN);
      end else if (size_ff > lpmf_pkg::CSR_W'(STORE_DEPTH)) begin
         eff_size = SW'(STORE_DEPTH);
      end else begin
         eff_size = size_ff[SW-1:0];
      end
   end

   always_comb begin
      rd_eff  = (SW'(rd_ff) >= eff_size) ? '0 : rd_ff;
      wr_eff  = (SW'(wr_ff) >= eff_size) ? '0 : wr_ff;
      rd_next = ((SW'(rd_eff) + SW'(1)) >= eff_size) ? '0 : rd_eff + AW'(1);
      wr_next = ((SW'(wr_eff) + SW'(1)) >= eff_size) ? '0 : wr_eff + AW'(1);
      free_space = (fill_ff >= eff_size) ? '0 : eff_size - fill_ff;
      len_clamped = (rd_data > BW'(MAX_MSG_LEN)) ? BW'(MAX_MSG_LEN) : rd_data;
      cnt_wide = (CW'(len_clamped) > CW'(fill_ff)) ? CW'(fill_ff) : CW'(len_clamped);
      cnt = cnt_wide[LW-1:0];
   end

   lpmf_ram #(
      .WIDTH (BW),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_eff),
      .wr_data (cmd.push_len ? BW'(req_len) : req_byte),
      .rd_en   (cmd.pop),
      .rd_addr (rd_eff),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      status.out_free     = out_free;
      status.msg_open     = (expect_ff != '0);
      status.len_too_long = (req_len > LW'(MAX_MSG_LEN));
      status.no_space     = (CW'(free_space) < (CW'(req_len) + CW'(1)));
      status.fill_zero    = (fill_ff == '0);
      status.msg_zero     = (msg_cnt_ff == '0);
      status.cnt_zero     = (cnt == '0);
      status.last_beat    = (remain_ff == LW'(1));
   end

   always_comb begin
      size_in    = csr_wr_en ? csr_wr_data : size_ff;
      rd_in      = cmd.pop ? rd_next : rd_ff;
      wr_in      = push ? wr_next : wr_ff;
      fill_in    = fill_ff;
      if (push && (fill_ff < eff_size)) begin
         fill_in = fill_ff + SW'(1);
      end else if (cmd.pop && (fill_ff != '0)) begin
         fill_in = fill_ff - SW'(1);
      end
      expect_in  = expect_ff;
      msg_cnt_in = msg_cnt_ff;
      if (cmd.push_len) begin
         expect_in = req_len;
         if (req_len == '0) begin
            msg_cnt_in = msg_cnt_ff + MW'(1);
         end
      end else if (cmd.push_data) begin
         expect_in = expect_ff - LW'(1);
         if (expect_ff == LW'(1)) begin
            msg_cnt_in = msg_cnt_ff + MW'(1);
         end
      end else if (cmd.msg_clr) begin
         msg_cnt_in = '0;
      end else if (cmd.msg_dec) begin
         msg_cnt_in = msg_cnt_ff - MW'(1);
      end
      cnt_len_in = cmd.load_cnt ? cnt : cnt_len_ff;
      remain_in  = remain_ff;
      if (cmd.load_cnt) begin
         remain_in = cnt;
      end else if (cmd.out_load && (cmd.out_sel == lpmf_pkg::OSEL_MSG)) begin
         remain_in = remain_ff - LW'(1);
      end
   end

   always_comb begin
      rsp_valid_in  = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_bval_in   = rsp_bval_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.out_load) begin
         case (cmd.out_sel)
            lpmf_pkg::OSEL_BYTE: begin
               rsp_status_in = lpmf_pkg::STAT_OK;
               rsp_byte_in   = rd_data;
               rsp_len_in    = '0;
               rsp_bval_in   = 1'b1;
               rsp_last_in   = 1'b1;
            end
            lpmf_pkg::OSEL_MSG: begin
               rsp_status_in = lpmf_pkg::STAT_OK;
               rsp_byte_in   = rd_data;
               rsp_len_in    = cnt_len_ff;
               rsp_bval_in   = 1'b1;
               rsp_last_in   = (remain_ff == LW'(1));
            end
            default: begin
               rsp_status_in = cmd.out_status;
               rsp_byte_in   = '0;
               rsp_len_in    = '0;
               rsp_bval_in   = 1'b0;
               rsp_last_in   = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= lpmf_pkg::CSR_SIZE_RESET;
         rd_ff        <= '0;
         wr_ff        <= '0;
         fill_ff      <= '0;
         msg_cnt_ff   <= '0;
         expect_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         fill_ff      <= fill_in;
         msg_cnt_ff   <= msg_cnt_in;
         expect_ff    <= expect_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff     <= remain_in;
      cnt_len_ff    <= cnt_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_bval_ff   <= rsp_bval_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_byte       = rsp_byte_ff;
   assign rsp_len        = rsp_len_ff;
   assign rsp_byte_valid = rsp_bval_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef ASSERT_OFF
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("Result register overwritten while a beat is still pending.");

   a_no_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(push && cmd.pop))
      else $error("Store written and read in the same cycle.");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (fill_ff != '0))
      else $error("Byte popped from an empty store.");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      push |=> (fill_ff <= SW'(STORE_DEPTH)))
      else $error("Fill count exceeds the store depth.");
`endif

endmodule

// ----- rtl/lpmf_ctrl.sv -----
// Controller state machine of the message FIFO: decodes each request and
// sequences store reads. Depends on lpmf_pkg.
module lpmf_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lpmf_pkg::FUNC_W-1:0]   req_func,
   input  lpmf_pkg::dp_status_type       status,
   output lpmf_pkg::ctrl_cmd_type        cmd
);

   lpmf_pkg::state_type state_ff, state_in;
   lpmf_pkg::func_type  func;
   logic                accept;
   logic                msg_empty;

   assign func       = lpmf_pkg::func_type'(req_func);
   assign req_tready = (state_ff == lpmf_pkg::S_IDLE) && status.out_free;
   assign accept     = req_tvalid && req_tready;
   assign msg_empty  = status.fill_zero || status.msg_zero;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpmf_pkg::S_IDLE: begin
            if (accept) begin
               if ((func == lpmf_pkg::FUNC_READ_BYTE) && !status.fill_zero) begin
                  state_in = lpmf_pkg::S_POP_WAIT;
               end else if ((func == lpmf_pkg::FUNC_READ_MSG) && !msg_empty) begin
                  state_in = lpmf_pkg::S_LEN_WAIT;
               end
            end
         end
         lpmf_pkg::S_POP_WAIT: begin
            state_in = lpmf_pkg::S_IDLE;
         end
         lpmf_pkg::S_LEN_WAIT: begin
            state_in = status.cnt_zero ? lpmf_pkg::S_IDLE : lpmf_pkg::S_DATA;
         end
         lpmf_pkg::S_DATA: begin
            if (status.out_free && status.last_beat) begin
               state_in = lpmf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lpmf_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.push_len   = 1'b0;
      cmd.push_data  = 1'b0;
      cmd.pop        = 1'b0;
      cmd.msg_dec    = 1'b0;
      cmd.msg_clr    = 1'b0;
      cmd.load_cnt   = 1'b0;
      cmd.out_load   = 1'b0;
      cmd.out_sel    = lpmf_pkg::OSEL_STATUS;
      cmd.out_status = lpmf_pkg::STAT_OK;
      case (state_ff)
         lpmf_pkg::S_IDLE: begin
            if (accept) begin
               case (func)
                  lpmf_pkg::FUNC_BEGIN: begin
                     cmd.out_load = 1'b1;
                     if (status.msg_open) begin
                        cmd.out_status = lpmf_pkg::STAT_IGNORED;
                     end else if (status.len_too_long) begin
                        cmd.out_status = lpmf_pkg::STAT_TOO_LONG;
                     end else if (status.no_space) begin
                        cmd.out_status = lpmf_pkg::STAT_DROPPED;
                     end else begin
                        cmd.push_len = 1'b1;
                     end
                  end
                  lpmf_pkg::FUNC_DATA: begin
                     cmd.out_load = 1'b1;
                     if (status.msg_open) begin
                        cmd.push_data = 1'b1;
                     end else begin
                        cmd.out_status = lpmf_pkg::STAT_IGNORED;
                     end
                  end
                  lpmf_pkg::FUNC_READ_BYTE: begin
                     if (status.fill_zero) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = lpmf_pkg::STAT_EMPTY;
                     end else begin
                        cmd.pop = 1'b1;
                     end
                  end
                  default: begin
                     cmd.msg_clr = status.fill_zero;
                     if (msg_empty) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = lpmf_pkg::STAT_EMPTY;
                     end else begin
                        cmd.pop     = 1'b1;
                        cmd.msg_dec = 1'b1;
                     end
                  end
               endcase
            end
         end
         lpmf_pkg::S_POP_WAIT: begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = lpmf_pkg::OSEL_BYTE;
         end
         lpmf_pkg::S_LEN_WAIT: begin
            if (status.cnt_zero) begin
               cmd.out_load = 1'b1;
            end else begin
               cmd.load_cnt = 1'b1;
               cmd.pop      = 1'b1;
            end
         end
         lpmf_pkg::S_DATA: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = lpmf_pkg::OSEL_MSG;
               cmd.pop      = !status.last_beat;
            end
         end
         default: begin
            cmd.out_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpmf_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/length_prefixed_message_fifo_core.sv -----
// Length-prefixed message FIFO with a registered result. Begin and data requests
// are answered from the idle state. A raw byte read pops the byte store and loads
// the byte from its registered read port in POP_WAIT; a message read pops the
// length, loads the beat count in LEN_WAIT, then sends each beat from DATA as the result frees.
// Synchronous active-high reset clears pointers, fill, message and expected counts and
// sets the size register (to 256); stored bytes are undefined until written.
module length_prefixed_message_fifo_core #(
   parameter int STORE_DEPTH = 256,
   parameter int MAX_MSG_LEN = 63
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [lpmf_pkg::CSR_W-1:0]           csr_wr_data,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lpmf_pkg::REQ_TDATA_W-1:0]     req_tdata,  // msg_len[5:0], data_byte[13:6]
   input  logic [lpmf_pkg::FUNC_W-1:0]          req_tuser,  // func[1:0]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lpmf_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // out_byte[7:0], out_len[13:8]
   output logic [lpmf_pkg::RSP_TUSER_W-1:0]     rsp_tuser,  // status[2:0], byte_valid[3]
   output logic                                 rsp_tlast
);

   lpmf_pkg::ctrl_cmd_type  cmd;
   lpmf_pkg::dp_status_type status;

   logic [lpmf_pkg::STATUS_W-1:0] rsp_status;
   logic [lpmf_pkg::BYTE_W-1:0]   rsp_byte;
   logic [lpmf_pkg::LEN_W-1:0]    rsp_len;
   logic                          rsp_byte_valid;

   lpmf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   lpmf_datapath #(
      .STORE_DEPTH (STORE_DEPTH),
      .MAX_MSG_LEN (MAX_MSG_LEN)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_len        (req_tdata[5:0]),
      .req_byte       (req_tdata[13:6]),
      .cmd            (cmd),
      .status         (status),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_status     (rsp_status),
      .rsp_byte       (rsp_byte),
      .rsp_len        (rsp_len),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_len, rsp_byte};
   assign rsp_tuser = {rsp_byte_valid, rsp_status};

endmodule
